// File: src/owd_pkg.sv
// ---------------------------------------------------------------------------
// owd_pkg
// shared types and constants for the overcurrent window debounce block
// ---------------------------------------------------------------------------
package owd_pkg;

    // register index codes on the configuration port
    localparam logic [1:0] REG_SENSOR_RANGE     = 2'd0;
    localparam logic [1:0] REG_OVER_CURRENT_MA  = 2'd1;
    localparam logic [1:0] REG_QUALIFY_LIMIT    = 2'd2;
    localparam logic [1:0] REG_DISQUALIFY_LIMIT = 2'd3;

    // sensor range codes
    localparam logic [1:0] RANGE_30A     = 2'd0;
    localparam logic [1:0] RANGE_20A     = 2'd1;
    localparam logic [1:0] RANGE_5A      = 2'd2;
    localparam logic [1:0] RANGE_30A_ALT = 2'd3;

    // full-scale current per range, milliamps
    localparam int unsigned MA_W = 15;
    localparam logic [MA_W-1:0] FULL_30A_MA = 15'd30000;
    localparam logic [MA_W-1:0] FULL_20A_MA = 15'd20000;
    localparam logic [MA_W-1:0] FULL_5A_MA  = 15'd5000;

    // register reset values
    localparam logic [15:0] OVER_CURRENT_RST   = 16'd30000;
    localparam logic [15:0] QUALIFY_RST        = 16'd10;
    localparam logic [15:0] DISQUALIFY_RST     = 16'd0;

    // derived configuration handed to the datapath
    typedef struct packed {
        logic [MA_W-1:0] full_ma;     // full-scale current of the range
        logic [MA_W-1:0] limit_ma;    // limit clamped to full scale
        logic [15:0]     qualify;
        logic [15:0]     disqualify;
    } t_owd_cfg;

    function automatic logic [MA_W-1:0] range_full_ma(input logic [1:0] code);
        logic [MA_W-1:0] full;
        full = FULL_30A_MA;
        unique case (code)
            RANGE_20A:               full = FULL_20A_MA;
            RANGE_5A:                full = FULL_5A_MA;
            RANGE_30A, RANGE_30A_ALT: full = FULL_30A_MA;
            default:                 full = FULL_30A_MA;
        endcase
        return full;
    endfunction

endpackage

// File: src/owd_cfg.sv
// ---------------------------------------------------------------------------
// owd_cfg
// configuration registers and the clamped limit
// ---------------------------------------------------------------------------
module owd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output owd_pkg::t_owd_cfg   o_cfg
);

    logic [1:0]  r_range;
    logic [15:0] r_over_ma;
    logic [15:0] r_qualify;
    logic [15:0] r_disqualify;

    logic [owd_pkg::MA_W-1:0] full_ma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range      <= owd_pkg::RANGE_30A;
            r_over_ma    <= owd_pkg::OVER_CURRENT_RST;
            r_qualify    <= owd_pkg::QUALIFY_RST;
            r_disqualify <= owd_pkg::DISQUALIFY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                owd_pkg::REG_SENSOR_RANGE:     r_range      <= i_cfg_data[1:0];
                owd_pkg::REG_OVER_CURRENT_MA:  r_over_ma    <= i_cfg_data;
                owd_pkg::REG_QUALIFY_LIMIT:    r_qualify    <= i_cfg_data;
                owd_pkg::REG_DISQUALIFY_LIMIT: r_disqualify <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        full_ma          = owd_pkg::range_full_ma(r_range);
        o_cfg.full_ma    = full_ma;
        // limit above full scale saturates at full scale
        o_cfg.limit_ma   = (r_over_ma > {1'b0, full_ma}) ? full_ma
                                                          : r_over_ma[owd_pkg::MA_W-1:0];
        o_cfg.qualify    = r_qualify;
        o_cfg.disqualify = r_disqualify;
    end

endmodule

// File: src/owd_window.sv
// ---------------------------------------------------------------------------
// owd_window
// window compare without a divider: distance from midscale times full scale
// against limit times midscale
// ---------------------------------------------------------------------------
module owd_window #(
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [ADC_BITS-1:0] i_sample,
    input  owd_pkg::t_owd_cfg   i_cfg,
    output logic                o_valid,
    output logic                o_out_win
);

    localparam int PROD_W = ADC_BITS + owd_pkg::MA_W;
    localparam logic [ADC_BITS-1:0] MID = ADC_BITS'(1) << (ADC_BITS - 1);

    // input register
    logic                r_s1_valid;
    logic [ADC_BITS-1:0] r_s1_sample;

    logic [ADC_BITS-1:0] mid_dist;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   thresh;

    // above midscale: sample >= MID + delta  <=>  limit*MID < (d+1)*full
    // below midscale: sample <  MID - delta  <=>  limit*MID < (MID-sample)*full
    always_comb begin
        if (r_s1_sample[ADC_BITS-1]) begin
            mid_dist = {1'b0, r_s1_sample[ADC_BITS-2:0]} + ADC_BITS'(1);
        end else begin
            mid_dist = MID - r_s1_sample;
        end
        prod   = PROD_W'(mid_dist) * PROD_W'(i_cfg.full_ma);
        thresh = {1'b0, i_cfg.limit_ma, {(ADC_BITS-1){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_sample <= i_sample;
        end
    end

    assign o_valid   = r_s1_valid;
    assign o_out_win = (prod > thresh);

endmodule

// File: src/owd_debounce.sv
// ---------------------------------------------------------------------------
// owd_debounce
// integrating counter, fault latch and result register
// ---------------------------------------------------------------------------
module owd_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_out_win,
    input  owd_pkg::t_owd_cfg i_cfg,
    output logic              o_valid,
    output logic              o_fault
);

    logic [15:0] r_count;
    logic        r_fault;
    logic        r_valid;
    logic [15:0] stepped;
    logic [15:0] n_count;
    logic        n_fault;

    always_comb begin
        if (i_out_win) begin
            stepped = (r_count < i_cfg.qualify) ? r_count + 16'd1 : r_count;
        end else begin
            stepped = (r_count > i_cfg.disqualify) ? r_count - 16'd1 : r_count;
        end
        n_count = stepped;
        n_fault = r_fault;
        if (!r_fault) begin
            if (stepped >= i_cfg.qualify) begin
                n_fault = 1'b1;
            end
        end else if (stepped <= i_cfg.disqualify) begin
            n_fault = 1'b0;
            n_count = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
            r_fault <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_count <= n_count;
                r_fault <= n_fault;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_fault = r_fault;

endmodule

// File: src/overcurrent_window_debounce.sv
// ---------------------------------------------------------------------------
// overcurrent_window_debounce
// debounced overcurrent flag from a stream of current-sensor adc samples
// ---------------------------------------------------------------------------
//  channel   direction  signals                               word
//  input     in         i_valid, o_stall, i_sample            one adc sample
//  output    out        o_valid, i_stall, o_fault             debounced fault flag
//  config    in         i_cfg_valid, o_cfg_ready, index, data one register write
//
//  one sample per cycle unless stalled; two register stages (input reg, result reg):
//  a sample is captured in the input reg and its flag in the result reg, which drives o_fault
//  the longest path is the adc x full-scale product, its compare and the counter step
//  a held result with i_stall high freezes the whole pipe and raises o_stall
//  reset is synchronous and active low: counter, flag and all valids clear,
//  registers return to 30 A range, 30000 mA limit, qualify 10, disqualify 0
// ---------------------------------------------------------------------------
module overcurrent_window_debounce #(
    parameter int ADC_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample stream
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ADC_BITS-1:0] i_sample,
    // fault stream
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_fault,
    // register writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    owd_pkg::t_owd_cfg cfg;

    logic en;          // pipe advances
    logic win_valid;
    logic win_out;

    // the pipe only stops when the result register holds an untaken word
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    owd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register and window compare
    owd_window #(
        .ADC_BITS (ADC_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .i_cfg     (cfg),
        .o_valid   (win_valid),
        .o_out_win (win_out)
    );

    // counter update and result register
    owd_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (win_valid),
        .i_out_win (win_out),
        .i_cfg     (cfg),
        .o_valid   (o_valid),
        .o_fault   (o_fault)
    );

endmodule

// File: src/owd_checker.sv
// ---------------------------------------------------------------------------
// owd_checker
// port-level checks for the overcurrent window debounce block
// ---------------------------------------------------------------------------
module owd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_fault
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_fault))
        else $error("result word changed under stall");

    // input stall only when the result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without blocked result");

    // input never stalled while the result is free to move
    a_no_extra_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && i_stall) |-> !o_stall)
        else $error("input stalled needlessly");

    // reset clears the result side and the fault
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_fault)
        else $error("reset did not clear result");

    // the fault flag only rises while a result word is valid
    a_fault_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_fault) |-> o_valid)
        else $error("fault rose without a result word");

endmodule

bind overcurrent_window_debounce owd_checker u_owd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_fault (o_fault)
);

// File: tb/overcurrent_window_debounce_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// overcurrent_window_debounce_tb
// drives adc sample words and register writes into the debounce block and
// checks every fault word against a cycle-free predictor of the window
// compare and integrating counter, under several idle and stall mixes
// ---------------------------------------------------------------------------
module overcurrent_window_debounce_tb;

    localparam int ADC_W           = 12;
    localparam int MIDSCALE        = 2048;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int TABLE_ROWS      = 34;
    localparam int FIXED_SETS      = 8;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    // one directed row: a register write or a sample word, optionally with
    // a fault value that is obvious by inspection
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  index;
        logic [15:0] data;
        logic [11:0] value;
        logic        fixed;
        logic        fault;
    } t_stim_row;

    typedef struct packed {
        logic [1:0]  range_code;
        logic [15:0] limit_ma;
        logic [15:0] qualify;
        logic [15:0] disqualify;
    } t_cfg_set;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [ADC_W-1:0]  i_sample;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_fault;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    // travels with each sample word so the checker knows a hand-typed value
    logic              row_fixed;
    logic              row_fault;

    // predictor copy of registers and state, reset values
    logic [1:0]        cfg_range      = owd_pkg::RANGE_30A;
    logic [15:0]       cfg_limit_ma   = owd_pkg::OVER_CURRENT_RST;
    logic [15:0]       cfg_qualify    = owd_pkg::QUALIFY_RST;
    logic [15:0]       cfg_disqualify = owd_pkg::DISQUALIFY_RST;
    logic [15:0]       debounce_count = 16'd0;
    logic              fault_state    = 1'b0;

    logic              pending_faults[$];
    int                errors       = 0;
    int                quiet_cycles = 0;
    int                gap_pct      = 0;
    int                stall_pct    = 0;
    bit                burst_out    = 1'b0;

    // directed rows: reset defaults, zero limit, clamped limit, the exact
    // window edges in every range, and qualify/disqualify at their extremes
    t_stim_row stim_table [TABLE_ROWS] = '{
        // after reset the 30 A window is full width, nothing is outside
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd0,    1'b1, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd4095, 1'b1, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2048, 1'b1, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2047, 1'b1, 1'b0},
        // zero limit: every sample outside, qualify of one trips at once
        '{ROW_CFG,    owd_pkg::REG_QUALIFY_LIMIT,    16'd1,    12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_OVER_CURRENT_MA,  16'd0,    12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2048, 1'b1, 1'b1},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd0,    1'b1, 1'b1},
        // limit above range is clamped, window full again, fault drops
        '{ROW_CFG,    owd_pkg::REG_OVER_CURRENT_MA,  16'hFFFF, 12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd4095, 1'b1, 1'b0},
        // 5 A range, half scale limit: edges at 1024 and 3072
        '{ROW_CFG,    owd_pkg::REG_SENSOR_RANGE,     16'd2,    12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_OVER_CURRENT_MA,  16'd2500, 12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_QUALIFY_LIMIT,    16'd3,    12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_DISQUALIFY_LIMIT, 16'd1,    12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd3072, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd1023, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd3071, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd1024, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd4095, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2048, 1'b0, 1'b0},
        // 20 A range: edges at 1792 and 2304
        '{ROW_CFG,    owd_pkg::REG_SENSOR_RANGE,     16'd1,    12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2304, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd1791, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2303, 1'b0, 1'b0},
        // code 3 acts as 30 A, qualify below disqualify
        '{ROW_CFG,    owd_pkg::REG_SENSOR_RANGE,     16'hFFFF, 12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_QUALIFY_LIMIT,    16'd0,    12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_DISQUALIFY_LIMIT, 16'hFFFF, 12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2218, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd1878, 1'b0, 1'b0},
        // qualify at its top value, counter never gets there
        '{ROW_CFG,    owd_pkg::REG_QUALIFY_LIMIT,    16'hFFFF, 12'd0,    1'b0, 1'b0},
        '{ROW_CFG,    owd_pkg::REG_DISQUALIFY_LIMIT, 16'd0,    12'd0,    1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd1877, 1'b0, 1'b0},
        '{ROW_SAMPLE, owd_pkg::REG_SENSOR_RANGE,     16'd0,    12'd2217, 1'b0, 1'b0}
    };

    // settings for the first random phases, extremes among them
    t_cfg_set cfg_sets [FIXED_SETS] = '{
        '{owd_pkg::RANGE_30A,     16'd5000,  16'd10, 16'd0},
        '{owd_pkg::RANGE_20A,     16'hFFFF,  16'd3,  16'd0},
        '{owd_pkg::RANGE_5A,      16'd2500,  16'd4,  16'd2},
        '{owd_pkg::RANGE_30A_ALT, 16'd0,     16'd0,  16'hFFFF},
        '{owd_pkg::RANGE_20A,     16'd12345, 16'd6,  16'd3},
        '{owd_pkg::RANGE_5A,      16'd1,     16'd1,  16'd0},
        '{owd_pkg::RANGE_30A,     16'd29999, 16'd5,  16'd5},
        '{owd_pkg::RANGE_30A_ALT, 16'd15000, 16'd3,  16'd7}
    };

    overcurrent_window_debounce #(
        .ADC_BITS(ADC_W)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sample(i_sample),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_fault(o_fault),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // half-width of the in-window band around midscale, in adc codes
    function automatic int window_delta();
        int full;
        int lim;
        case (cfg_range)
            owd_pkg::RANGE_20A: full = int'(owd_pkg::FULL_20A_MA);
            owd_pkg::RANGE_5A:  full = int'(owd_pkg::FULL_5A_MA);
            default:            full = int'(owd_pkg::FULL_30A_MA);
        endcase
        lim = int'(cfg_limit_ma);
        if (lim > full) lim = full;
        return lim * MIDSCALE / full;
    endfunction

    // steps the integrating counter for one sample and returns the flag
    function automatic logic predict_fault(input logic [ADC_W-1:0] value);
        int d;
        bit outside;
        d = window_delta();
        outside = (int'(value) >= MIDSCALE + d) || (int'(value) < MIDSCALE - d);
        if (outside) begin
            if (debounce_count < cfg_qualify) debounce_count += 16'd1;
        end else if (debounce_count > cfg_disqualify) begin
            debounce_count -= 16'd1;
        end
        if (!fault_state) begin
            if (debounce_count >= cfg_qualify) fault_state = 1'b1;
        end else if (debounce_count <= cfg_disqualify) begin
            fault_state = 1'b0;
            debounce_count = 16'd0;
        end
        return fault_state;
    endfunction

    // mostly runs of in-window or out-of-window samples, some near the
    // edges, some plain noise
    function automatic logic [ADC_W-1:0] pick_sample(input bit want_out);
        int d;
        int lo;
        int hi;
        int roll;
        int v;
        d = window_delta();
        lo = MIDSCALE - d;
        hi = MIDSCALE + d;
        roll = $urandom_range(99);
        v = $urandom_range(4095);
        if (roll < 15) begin
            v = (($urandom_range(1) == 0) ? lo : hi) + int'($urandom_range(4)) - 2;
        end else if (roll >= 25) begin
            if (want_out && d < MIDSCALE) begin
                if ($urandom_range(1) == 0) v = $urandom_range(4095, hi);
                else                         v = $urandom_range(lo - 1, 0);
            end else if (!want_out && d > 0) begin
                v = $urandom_range(hi - 1, lo);
            end
        end
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[ADC_W-1:0];
    endfunction

    // offers one sample word, with random idle cycles ahead of it
    task automatic drive_sample(input logic [ADC_W-1:0] value, input logic fixed,
                                input logic fixed_fault);
        while ($urandom_range(99) < gap_pct) begin
            i_valid  <= 1'b0;
            i_sample <= ADC_W'($urandom_range(4095));
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample  <= value;
        row_fixed <= fixed;
        row_fault <= fixed_fault;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // register write, only once every fault word in flight has come back
    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_faults.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // tracks accepted writes and samples, checks fault words in order
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    owd_pkg::REG_SENSOR_RANGE:     cfg_range      = i_cfg_data[1:0];
                    owd_pkg::REG_OVER_CURRENT_MA:  cfg_limit_ma   = i_cfg_data;
                    owd_pkg::REG_QUALIFY_LIMIT:    cfg_qualify    = i_cfg_data;
                    owd_pkg::REG_DISQUALIFY_LIMIT: cfg_disqualify = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                want = predict_fault(i_sample);
                // hand-typed rows override, the predictor state still advances
                pending_faults.push_back(row_fixed ? row_fault : want);
            end
            if (o_valid && !i_stall) begin
                if (pending_faults.size() == 0) begin
                    $error("fault word with nothing pending, fault = %0b", o_fault);
                    errors++;
                end else begin
                    want = pending_faults.pop_front();
                    if (o_fault !== want) begin
                        $error("fault mismatch: expected %0b, actual %0b", want, o_fault);
                        errors++;
                    end
                end
            end
        end
    end

    // ends the run when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_cfg_set    cs;
        logic [15:0] range_word;
        int          row;
        int          phase;
        int          n;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = owd_pkg::REG_SENSOR_RANGE;
        i_cfg_data  = '0;
        row_fixed   = 1'b0;
        row_fault   = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        for (row = 0; row < TABLE_ROWS; row++) begin
            if (stim_table[row].kind == ROW_CFG)
                write_reg(stim_table[row].index, stim_table[row].data);
            else
                drive_sample(stim_table[row].value, stim_table[row].fixed,
                             stim_table[row].fault);
        end

        // random part: one register setting per phase, idle mix rotates
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < FIXED_SETS) begin
                cs = cfg_sets[phase];
            end else begin
                cs.range_code = 2'($urandom_range(3));
                cs.limit_ma   = ($urandom_range(3) == 0) ? 16'hFFFF
                                                         : 16'($urandom_range(32000));
                cs.qualify    = 16'($urandom_range(24));
                cs.disqualify = 16'($urandom_range(cs.qualify));
            end
            // upper data bits of the range write are don't-care, keep them random
            range_word = 16'($urandom);
            range_word[1:0] = cs.range_code;
            write_reg(owd_pkg::REG_SENSOR_RANGE, range_word);
            write_reg(owd_pkg::REG_OVER_CURRENT_MA, cs.limit_ma);
            write_reg(owd_pkg::REG_QUALIFY_LIMIT, cs.qualify);
            write_reg(owd_pkg::REG_DISQUALIFY_LIMIT, cs.disqualify);

            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(11) == 0) burst_out = !burst_out;
                drive_sample(pick_sample(burst_out), 1'b0, 1'b0);
            end
        end

        // drain, then keep watching for stray words
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_faults.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
